// ===== src/ir_command_frame_encoder_core_assert.svh =====
// assertion macros for the ir command frame encoder
`ifndef IR_COMMAND_FRAME_ENCODER_CORE_ASSERT_SVH
`define IR_COMMAND_FRAME_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IRFE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IRFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/irfe_pkg.sv =====
// shared types and constants for the ir command frame encoder
package irfe_pkg;

    localparam int unsigned FRAME_W  = 48;
    localparam int unsigned NBITS_W  = 6;
    localparam int unsigned SENDS_W  = 9;
    localparam int unsigned FRAMES_W = 10;

    // protocol selector codes
    localparam logic [2:0] FUNC_NECEXT   = 3'd0;
    localparam logic [2:0] FUNC_SIRC12   = 3'd1;
    localparam logic [2:0] FUNC_SIRC15   = 3'd2;
    localparam logic [2:0] FUNC_SIRC20   = 3'd3;
    localparam logic [2:0] FUNC_KASEIKYO = 3'd4;

    // frame lengths
    localparam logic [NBITS_W-1:0] NBITS_NONE   = 6'd0;
    localparam logic [NBITS_W-1:0] NBITS_SIRC12 = 6'd12;
    localparam logic [NBITS_W-1:0] NBITS_SIRC15 = 6'd15;
    localparam logic [NBITS_W-1:0] NBITS_SIRC20 = 6'd20;
    localparam logic [NBITS_W-1:0] NBITS_NECEXT = 6'd32;
    localparam logic [NBITS_W-1:0] NBITS_KSK    = 6'd48;

    typedef enum logic [1:0] {
        KIND_NEC  = 2'd0,
        KIND_SIRC = 2'd1,
        KIND_KSK  = 2'd2,
        KIND_BAD  = 2'd3
    } t_kind;

    // decode stage: frame bits in transmit-reversed order, check byte still open
    typedef struct packed {
        t_kind               kind;
        logic [NBITS_W-1:0]  nbits;
        logic [SENDS_W-1:0]  sends;
        logic [39:0]         raw;
    } t_decode;

    // assembled frame, lsb is the first bit sent
    typedef struct packed {
        logic [FRAME_W-1:0]  data;
        logic [NBITS_W-1:0]  nbits;
        logic [FRAMES_W-1:0] frames;
        logic                bad;
    } t_frame;

endpackage

// ===== src/irfe_reverse.sv =====
// output stage: reverses the frame over its length and registers the result
module irfe_reverse
    import irfe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_frame             i_frame,
    output logic               o_valid,
    output t_frame             o_frame
);

    logic [FRAME_W-1:0] w_rev;
    logic [NBITS_W-1:0] w_shift;
    logic               r_valid;
    t_frame             r_frame;
    t_frame             n_frame;

    always_comb begin
        for (int i = 0; i < FRAME_W; i++) begin
            w_rev[i] = i_frame.data[FRAME_W-1-i];
        end
        w_shift = NBITS_KSK - i_frame.nbits;
        n_frame = i_frame;
        // full-width reverse, then right-align over the frame length
        n_frame.data = w_rev >> w_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

endmodule

// ===== src/ir_command_frame_encoder_core.sv =====
// top level of the ir command frame encoder: decode, assemble and reverse stages
//
// usage:
//   command channel: drive i_func, i_address_word and i_command_word with i_start
//   high; a word is taken at every rising edge where i_start is high and o_busy is
//   low. o_busy never rises, so one word can enter in every cycle.
//   result channel: o_done is high for exactly one cycle with o_frame_data,
//   o_bit_count, o_frames_total and o_bad_protocol; the receiver takes it at the
//   edge that ends that cycle and cannot stall it.
//   config channel: i_cfg_data is written into extra_repeats when i_cfg_valid and
//   o_cfg_ready are high; o_cfg_ready is always high. write it only while idle.
// pipeline: the accepting edge loads the decode register, then the word passes the
//   assemble register and the reverse/output register before the result is taken.
// throughput: one word per cycle, set by the three-stage register pipeline.
// reset: i_rst_n low at a rising edge clears the stage valid bits and sets
//   extra_repeats to zero; words in flight are dropped.
// frame_data is right-aligned, the first bit sent is bit bit_count-1.
module ir_command_frame_encoder_core
    import irfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                i_start,
    output logic                o_busy,
    input  logic [2:0]          i_func,
    input  logic [31:0]         i_address_word,
    input  logic [31:0]         i_command_word,
    // config channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    // result channel
    output logic                o_done,
    output logic [FRAME_W-1:0]  o_frame_data,
    output logic [NBITS_W-1:0]  o_bit_count,
    output logic [FRAMES_W-1:0] o_frames_total,
    output logic                o_bad_protocol
);

    logic          w_accept;
    logic [7:0]    r_extra_repeats;

    // stage 1: decode
    logic          r_s1_valid;
    t_decode       r_s1;
    t_decode       n_s1;

    // stage 2: assemble
    logic          r_s2_valid;
    t_frame        r_s2;
    t_frame        n_s2;

    // stage 3 lives in the reverse block
    logic          w_s3_valid;
    t_frame        w_s3;

    // kaseikyo byte fields
    logic [7:0]    w_b0;
    logic [7:0]    w_b1;
    logic [7:0]    w_par;
    logic [3:0]    w_par4;
    logic [9:0]    w_d;
    logic [7:0]    w_b2;
    logic [7:0]    w_b3;
    logic [7:0]    w_b4;
    logic [7:0]    w_b5;

    // sirc byte-swapped fields
    logic [15:0]   w_sa;
    logic [6:0]    w_sc;

    // no backpressure anywhere in the pipe
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra_repeats <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_extra_repeats <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------- decode
    always_comb begin
        // sirc: address low byte from byte 3, high byte from byte 2
        w_sa   = {i_address_word[23:16], i_address_word[31:24]};
        w_sc   = i_command_word[30:24];
        // kaseikyo: vendor bytes, nibble parity, 10-bit data
        w_b0   = i_address_word[23:16];
        w_b1   = i_address_word[15:8];
        w_par  = w_b0 ^ w_b1;
        w_par4 = w_par[3:0] ^ w_par[7:4];
        w_d    = {i_command_word[17:16], i_command_word[31:24]};
        w_b2   = {i_address_word[31:28], w_par4};
        w_b3   = {w_d[3:0], i_address_word[27:24]};
        w_b4   = {i_address_word[1:0], w_d[9:4]};

        n_s1.sends = {1'b0, r_extra_repeats} + SENDS_W'(1);
        n_s1.raw   = '0;
        unique case (i_func) inside
            FUNC_NECEXT: begin
                // reversing {cmd, addr} over 32 bits equals two 16-bit reversals
                n_s1.kind  = KIND_NEC;
                n_s1.nbits = NBITS_NECEXT;
                n_s1.raw   = {8'd0, i_command_word[7:0], i_command_word[15:8],
                              i_address_word[7:0], i_address_word[15:8]};
            end
            FUNC_SIRC12: begin
                n_s1.kind  = KIND_SIRC;
                n_s1.nbits = NBITS_SIRC12;
                n_s1.raw   = {28'd0, w_sa[4:0], w_sc};
            end
            FUNC_SIRC15: begin
                n_s1.kind  = KIND_SIRC;
                n_s1.nbits = NBITS_SIRC15;
                n_s1.raw   = {25'd0, w_sa[7:0], w_sc};
            end
            FUNC_SIRC20: begin
                n_s1.kind  = KIND_SIRC;
                n_s1.nbits = NBITS_SIRC20;
                n_s1.raw   = {20'd0, w_sa[12:0], w_sc};
            end
            FUNC_KASEIKYO: begin
                n_s1.kind  = KIND_KSK;
                n_s1.nbits = NBITS_KSK;
                n_s1.raw   = {w_b4, w_b3, w_b2, w_b1, w_b0};
            end
            default: begin
                n_s1.kind  = KIND_BAD;
                n_s1.nbits = NBITS_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // -------------------------------------------------------------- assemble
    always_comb begin
        // check byte is the xor of bytes two to four
        w_b5 = r_s1.raw[39:32] ^ r_s1.raw[31:24] ^ r_s1.raw[23:16];

        n_s2.nbits = r_s1.nbits;
        case (r_s1.kind)
            KIND_NEC: begin
                n_s2.data   = {8'd0, r_s1.raw};
                n_s2.frames = {1'b0, r_s1.sends};
                n_s2.bad    = 1'b0;
            end
            KIND_SIRC: begin
                // three frames per transmission
                n_s2.data   = {8'd0, r_s1.raw};
                n_s2.frames = {1'b0, r_s1.sends} + {r_s1.sends, 1'b0};
                n_s2.bad    = 1'b0;
            end
            KIND_KSK: begin
                n_s2.data   = {w_b5, r_s1.raw};
                n_s2.frames = {1'b0, r_s1.sends};
                n_s2.bad    = 1'b0;
            end
            default: begin
                // nothing is sent for an unknown selector
                n_s2.data   = '0;
                n_s2.frames = '0;
                n_s2.bad    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    // --------------------------------------------------------------- reverse
    irfe_reverse u_reverse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_frame (r_s2),
        .o_valid (w_s3_valid),
        .o_frame (w_s3)
    );

    assign o_done         = w_s3_valid;
    assign o_frame_data   = w_s3.data;
    assign o_bit_count    = w_s3.nbits;
    assign o_frames_total = w_s3.frames;
    assign o_bad_protocol = w_s3.bad;

    // ------------------------------------------------------------ assertions
`include "ir_command_frame_encoder_core_assert.svh"

    `IRFE_ASSERT_IMPL(a_latency, w_accept, ##3 o_done, "accepted word did not finish in three cycles")
    `IRFE_ASSERT_IMPL(a_no_orphan, o_done, $past(w_accept, 3), "result without an accepted word")
    `IRFE_ASSERT_IMPL(a_bad_len, o_done, o_bad_protocol == (o_bit_count == NBITS_NONE), "error flag and length disagree")
    `IRFE_ASSERT_IMPL(a_frames, o_done && !o_bad_protocol, o_frames_total != '0, "valid frame with zero frame count")
    `IRFE_ASSERT_NEXT(a_s2_follow, r_s1_valid, r_s2_valid, "decode stage word lost before assemble")

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the ir command frame encoder core
module tb_top;
    import irfe_pkg::*;

    // selector codes that name no protocol
    localparam logic [2:0] FUNC_UNUSED_LO  = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_MID = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_HI  = 3'd7;

    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_WORDS = 272;
    localparam int unsigned TAIL_CYCLES = 10;

    // one directed word; the typed-in frame is used only where typed is set
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] addr;
        logic [31:0] cmd;
        logic        typed;
        t_frame      want;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [2:0]          i_func;
    logic [31:0]         i_address_word;
    logic [31:0]         i_command_word;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [7:0]          i_cfg_data;
    logic                o_done;
    logic [FRAME_W-1:0]  o_frame_data;
    logic [NBITS_W-1:0]  o_bit_count;
    logic [FRAMES_W-1:0] o_frames_total;
    logic                o_bad_protocol;

    // predictor copy of extra_repeats, updated at the accepting edge
    logic [7:0] repeats_cfg;
    // frames still owed by the block, oldest first
    t_frame     pending_frames[$];
    int unsigned fail_count;
    // when set, the sender runs back to back with no gaps
    bit          burst_mode;

    // directed words: extremes, every protocol, ignored bytes, bad selectors
    // typed-in frame counts assume extra_repeats is zero
    t_stim_row stim_rows [22] = '{
        '{FUNC_NECEXT, 32'h0000_0000, 32'h0000_0000, 1'b1,
          {48'h0, NBITS_NECEXT, 10'd1, 1'b0}},
        '{FUNC_NECEXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          {48'h0000_FFFF_FFFF, NBITS_NECEXT, 10'd1, 1'b0}},
        '{FUNC_NECEXT, 32'h0000_00A5, 32'h0000_3C01, 1'b0, '0},
        // upper halves are ignored by necext
        '{FUNC_NECEXT, 32'hFFFF_0000, 32'hFFFF_0000, 1'b1,
          {48'h0, NBITS_NECEXT, 10'd1, 1'b0}},
        '{FUNC_SIRC12, 32'h0000_0000, 32'h0000_0000, 1'b1,
          {48'h0, NBITS_SIRC12, 10'd3, 1'b0}},
        '{FUNC_SIRC12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          {48'h0FFF, NBITS_SIRC12, 10'd3, 1'b0}},
        // sirc reads only the top bytes of the words
        '{FUNC_SIRC12, 32'h0000_FFFF, 32'h00FF_FFFF, 1'b1,
          {48'h0, NBITS_SIRC12, 10'd3, 1'b0}},
        '{FUNC_SIRC12, 32'h1234_5678, 32'h9A00_0000, 1'b0, '0},
        '{FUNC_SIRC15, 32'h0000_0000, 32'h0000_0000, 1'b1,
          {48'h0, NBITS_SIRC15, 10'd3, 1'b0}},
        '{FUNC_SIRC15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          {48'h7FFF, NBITS_SIRC15, 10'd3, 1'b0}},
        '{FUNC_SIRC15, 32'hA5C3_0000, 32'h8000_0000, 1'b0, '0},
        '{FUNC_SIRC20, 32'h0000_0000, 32'h0000_0000, 1'b1,
          {48'h0, NBITS_SIRC20, 10'd3, 1'b0}},
        '{FUNC_SIRC20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          {48'hF_FFFF, NBITS_SIRC20, 10'd3, 1'b0}},
        '{FUNC_SIRC20, 32'h0FE1_0000, 32'h7F00_0000, 1'b0, '0},
        '{FUNC_KASEIKYO, 32'h0000_0000, 32'h0000_0000, 1'b1,
          {48'h0, NBITS_KSK, 10'd1, 1'b0}},
        '{FUNC_KASEIKYO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          {48'hFFFF_0FFF_FF0F, NBITS_KSK, 10'd1, 1'b0}},
        '{FUNC_KASEIKYO, 32'h0123_4567, 32'h89AB_CDEF, 1'b0, '0},
        '{FUNC_KASEIKYO, 32'hA1B2_C3D4, 32'hFFFF_0000, 1'b0, '0},
        // kaseikyo ignores the low command bytes
        '{FUNC_KASEIKYO, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0, '0},
        '{FUNC_UNUSED_LO, 32'h0000_0000, 32'h0000_0000, 1'b1,
          {48'h0, NBITS_NONE, 10'd0, 1'b1}},
        '{FUNC_UNUSED_MID, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1,
          {48'h0, NBITS_NONE, 10'd0, 1'b1}},
        '{FUNC_UNUSED_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          {48'h0, NBITS_NONE, 10'd0, 1'b1}}
    };

    ir_command_frame_encoder_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_func         (i_func),
        .i_address_word (i_address_word),
        .i_command_word (i_command_word),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_frame_data   (o_frame_data),
        .o_bit_count    (o_bit_count),
        .o_frames_total (o_frames_total),
        .o_bad_protocol (o_bad_protocol)
    );

    // period of 4 time units
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // reverse the low n bits of v
    function automatic logic [47:0] mirror_bits(input logic [47:0] v, input int unsigned n);
        logic [47:0] r;
        r = '0;
        for (int unsigned i = 0; i < n; i++) begin
            r[n-1-i] = v[i];
        end
        return r;
    endfunction

    // frame the block should produce for one command word
    function automatic t_frame encode_frame(input logic [2:0] fn, input logic [31:0] a,
                                            input logic [31:0] c);
        t_frame      f;
        logic [8:0]  sends;
        logic [15:0] nec_a;
        logic [15:0] nec_c;
        logic [15:0] sa;
        logic [12:0] amask;
        logic [19:0] sirc_bits;
        logic [31:0] na;
        logic [15:0] nc;
        logic [9:0]  d;
        logic [7:0]  b0, b1, b2, b3, b4, b5, p;
        logic [3:0]  par;
        f = '0;
        sends = {1'b0, repeats_cfg} + 9'd1;
        case (fn)
            FUNC_NECEXT: begin
                // byte swap each 16-bit word, then send it lsb first
                nec_a = {a[7:0], a[15:8]};
                nec_c = {c[7:0], c[15:8]};
                f.data = (mirror_bits(48'(nec_a), 16) << 16) | mirror_bits(48'(nec_c), 16);
                f.nbits = NBITS_NECEXT;
                f.frames = {1'b0, sends};
            end
            FUNC_SIRC12, FUNC_SIRC15, FUNC_SIRC20: begin
                // address from the top two bytes, low byte first; command from byte 3
                sa = {a[23:16], a[31:24]};
                if (fn == FUNC_SIRC12) begin
                    amask = 13'h001F;
                    f.nbits = NBITS_SIRC12;
                end else if (fn == FUNC_SIRC15) begin
                    amask = 13'h00FF;
                    f.nbits = NBITS_SIRC15;
                end else begin
                    amask = 13'h1FFF;
                    f.nbits = NBITS_SIRC20;
                end
                sirc_bits = {sa[12:0] & amask, c[30:24]};
                f.data = mirror_bits(48'(sirc_bits), int'(f.nbits));
                f.frames = {1'b0, sends} * 10'd3;
            end
            FUNC_KASEIKYO: begin
                na = {a[7:0], a[15:8], a[23:16], a[31:24]};
                nc = {c[23:16], c[31:24]};
                d = nc[9:0];
                b0 = na[15:8];
                b1 = na[23:16];
                // vendor parity folds the two vendor bytes into a nibble
                p = b0 ^ b1;
                par = p[3:0] ^ p[7:4];
                b2 = {na[7:4], par};
                b3 = {d[3:0], na[3:0]};
                b4 = {na[25:24], d[9:4]};
                b5 = b2 ^ b3 ^ b4;
                f.data = mirror_bits({b5, b4, b3, b2, b1, b0}, 48);
                f.nbits = NBITS_KSK;
                f.frames = {1'b0, sends};
            end
            default: begin
                f.bad = 1'b1;
            end
        endcase
        return f;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // word content with the all-zero and all-one corners weighted up
    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return 32'h0000_0000;
        end else if (r == 1) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    // present one command word and hold it until the block takes it
    task automatic send_word(input logic [2:0] fn, input logic [31:0] a, input logic [31:0] c,
                             input logic typed, input t_frame typed_want);
        @(negedge i_clk);
        i_start        <= 1'b1;
        i_func         <= fn;
        i_address_word <= a;
        i_command_word <= c;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
        // taken at this edge
        pending_frames.push_back(typed ? typed_want : encode_frame(fn, a, c));
    endtask

    // idle gap after a word; a zero gap keeps start high
    task automatic idle_sender(input int unsigned gap);
        if (gap != 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and let every owed frame come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // write extra_repeats through the config channel
    task automatic write_repeats(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        repeats_cfg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result checker: every strobe must match the oldest owed frame
    always @(posedge i_clk) begin : result_check
        t_frame want;
        if (i_rst_n && o_done) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected result word, frame_data %h bit_count %0d",
                         $time, o_frame_data, o_bit_count);
                fail_count++;
            end else begin
                want = pending_frames.pop_front();
                if (o_frame_data !== want.data) begin
                    $display("%0t: frame_data expected %h actual %h",
                             $time, want.data, o_frame_data);
                    fail_count++;
                end
                if (o_bit_count !== want.nbits) begin
                    $display("%0t: bit_count expected %0d actual %0d",
                             $time, want.nbits, o_bit_count);
                    fail_count++;
                end
                if (o_frames_total !== want.frames) begin
                    $display("%0t: frames_total expected %0d actual %0d",
                             $time, want.frames, o_frames_total);
                    fail_count++;
                end
                if (o_bad_protocol !== want.bad) begin
                    $display("%0t: bad_protocol expected %b actual %b",
                             $time, want.bad, o_bad_protocol);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial begin : stimulus
        logic [7:0]  phase_repeats [PHASES];
        logic [2:0]  fn;
        int unsigned r;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_func         = FUNC_NECEXT;
        i_address_word = '0;
        i_command_word = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeats_cfg    = '0;
        fail_count     = 0;
        burst_mode     = 1'b0;
        // both extremes of extra_repeats plus a few in between
        phase_repeats[0] = 8'd255;
        phase_repeats[1] = 8'd1;
        phase_repeats[2] = 8'($urandom_range(2, 254));
        phase_repeats[3] = 8'd0;
        phase_repeats[4] = 8'd128;
        phase_repeats[5] = 8'($urandom);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words run with extra_repeats at zero
        write_repeats(8'd0);
        foreach (stim_rows[i]) begin
            send_word(stim_rows[i].func, stim_rows[i].addr, stim_rows[i].cmd,
                      stim_rows[i].typed, stim_rows[i].want);
            idle_sender(pick_gap());
        end

        // random phases, each under its own extra_repeats setting
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            // the sender pauses here until every owed frame has come
            wait_drained();
            write_repeats(phase_repeats[ph]);
            // one phase runs fully back to back
            burst_mode = (ph == 1);
            for (int unsigned k = 0; k < PHASE_WORDS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 90) begin
                    fn = 3'($urandom_range(FUNC_NECEXT, FUNC_KASEIKYO));
                end else begin
                    fn = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
                end
                send_word(fn, pick_word(), pick_word(), 1'b0, '0);
                // occasional stretches with no idling at all
                if (!burst_mode && $urandom_range(0, 49) == 0) begin
                    burst_mode = 1'b1;
                end else if (ph != 1 && burst_mode && $urandom_range(0, 19) == 0) begin
                    burst_mode = 1'b0;
                end
                idle_sender(pick_gap());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ir_command_frame_encoder_core test passed");
        end else begin
            $display("ir_command_frame_encoder_core test failed");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin : watchdog
        #2000000;
        $display("ir_command_frame_encoder_core test failed");
        $finish;
    end

endmodule
